// File: sv/particle_pool_update_assert.svh
// Assertion macros shared by the particle pool checker.
`ifndef PARTICLE_POOL_UPDATE_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_ASSERT_SVH

// Checked only while out of reset.
`define PPU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("particle pool assertion failed");

// Checked on every edge, reset included.
`define PPU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("particle pool assertion failed");

`endif

// File: sv/ppu_pkg.sv
// Shared types, constants and helpers of the particle pool.
`timescale 1ns / 1ps
package ppu_pkg;

    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    localparam logic [16:0]        LIFE_FULL   = 17'd65536;
    localparam logic signed [15:0] ALPHA_SPAWN = 16'sd24576;
    localparam logic signed [15:0] ALPHA_MIN   = -16'sd32768;
    localparam logic signed [19:0] POS_MAX     = 20'sd524287;
    localparam logic signed [19:0] POS_MIN     = -20'sd524288;
    // Reciprocal of ten: 2^23 / 10 rounded up, and the jitter form 2^15 / 10.
    localparam logic [19:0]        RECIP10     = 20'd838861;
    localparam logic [11:0]        RECIP10_J   = 12'd3277;
    localparam logic [20:0]        VEL_BIAS    = 21'd524295;
    localparam logic [17:0]        VEL_UNBIAS  = 18'd52429;
    localparam logic [11:0]        JIT_BIAS    = 12'd1045;
    localparam logic [8:0]         JIT_UNBIAS  = 9'd104;

    typedef struct packed {
        op_t                op;
        logic [15:0]        step_time;
        logic [16:0]        alpha_step;
        logic signed [19:0] source_x;
        logic signed [19:0] source_y;
        logic signed [19:0] source_vx;
        logic signed [19:0] source_vy;
        logic signed [19:0] shift_x;
        logic signed [19:0] shift_y;
        logic signed [6:0]  jitter;
        logic [6:0]         shade;
        logic [8:0]         slot_to_read;
    } cmd_t;

    typedef struct packed {
        logic [16:0]        life;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic [6:0]         shade;
        logic signed [15:0] alpha;
    } rec_t;

    typedef struct packed {
        logic [8:0]         slot;
        logic [9:0]         live;
        logic               alive;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [6:0]         shade;
        logic signed [15:0] alpha;
    } res_t;

    function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
        logic signed [19:0] r;
        if (v > 22'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < 22'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

// File: sv/ppu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ppu_ram #(
    parameter int WIDTH = 120,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/ppu_front.sv
// Front end: accepts input words, classifies them and queues commands.
`timescale 1ns / 1ps
module ppu_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                enable,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [15:0]         s_step_time,
    input  logic signed [19:0]  s_source_x,
    input  logic signed [19:0]  s_source_y,
    input  logic signed [19:0]  s_source_vx,
    input  logic signed [19:0]  s_source_vy,
    input  logic signed [19:0]  s_shift_x,
    input  logic signed [19:0]  s_shift_y,
    input  logic signed [6:0]   s_jitter_tenths,
    input  logic [6:0]          s_shade_hundredths,
    input  logic [8:0]          s_slot_to_read,
    output logic                cmd_valid,
    output ppu_pkg::cmd_t       cmd,
    input  logic                cmd_pop
);
    import ppu_pkg::*;

    cmd_t        q_reg [2];
    logic        rd_ptr_reg;
    logic        wr_ptr_reg;
    logic [1:0]  cnt_reg;
    cmd_t        in_cmd;
    logic        push;
    logic [18:0] dt5;

    // Alpha falls by 2.5 dt; in Q2.14 against Q0.16 that is dt*5/8, rounded.
    assign dt5 = 19'({s_step_time, 2'b00}) + 19'(s_step_time) + 19'd4;

    always_comb begin
        in_cmd              = '0;
        in_cmd.op           = op_t'(s_mode);
        in_cmd.step_time    = s_step_time;
        in_cmd.alpha_step   = 17'(dt5[18:3]);
        in_cmd.source_x     = s_source_x;
        in_cmd.source_y     = s_source_y;
        in_cmd.source_vx    = s_source_vx;
        in_cmd.source_vy    = s_source_vy;
        in_cmd.shift_x      = s_shift_x;
        in_cmd.shift_y      = s_shift_y;
        in_cmd.jitter       = s_jitter_tenths;
        in_cmd.shade        = s_shade_hundredths;
        in_cmd.slot_to_read = s_slot_to_read;
    end

    assign s_ready   = enable && (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(cmd_pop);
        end
    end
endmodule

// File: sv/ppu_engine.sv
// Back end: clears the pool, runs spawn searches, ticks, reads and no-op count replies.
`timescale 1ns / 1ps
module ppu_engine #(
    parameter int PARTICLES = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    output logic               ready_for_words,
    input  logic               cmd_valid,
    input  ppu_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ppu_pkg::res_t      res
);
    import ppu_pkg::*;

    localparam int IW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int CW = $clog2(PARTICLES + 1);
    localparam int XW = (IW > 9) ? IW : 9;
    localparam int LW = (CW > 10) ? CW : 10;
    localparam int RW = $bits(rec_t);

    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_SCAN, ST_SPWR, ST_TICK, ST_RD, ST_RDWAIT, ST_RESP
    } state_t;

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [IW-1:0]      ptr_reg;
    logic [IW-1:0]      start_reg;
    logic [IW-1:0]      slot_reg;
    logic               dead_reg;
    logic [CW-1:0]      issued_reg;
    logic [CW-1:0]      chk_reg;
    logic [CW-1:0]      live_reg;
    logic [CW-1:0]      acc_reg;
    logic               rd_valid_reg;
    logic [IW-1:0]      rd_addr_reg;
    logic               s2_valid_reg;
    logic [IW-1:0]      s2_addr_reg;
    logic [16:0]        s2_life_reg;
    rec_t               s2_rec_reg;
    logic signed [36:0] s2_mx_reg;
    logic signed [36:0] s2_my_reg;
    logic [40:0]        mvx_reg;
    logic [40:0]        mvy_reg;
    logic [23:0]        mj_reg;
    res_t               res_reg;
    res_t               out_reg;
    logic               m_valid_reg;

    logic               we;
    logic [IW-1:0]      waddr;
    rec_t               wdata;
    logic [IW-1:0]      raddr;
    logic [RW-1:0]      rdata_raw;
    rec_t               rdata;

    logic [XW-1:0]      rd_slot_x;
    logic               rd_in_range;
    logic [IW-1:0]      rd_idx;
    logic [CW-1:0]      live_spawn;
    rec_t               spawn_rec;
    rec_t               tick_rec;
    logic [16:0]        life_new;
    logic signed [20:0] step_x;
    logic signed [20:0] step_y;
    logic signed [17:0] alpha_dec;
    logic signed [9:0]  jq;
    logic signed [19:0] vel_x;
    logic signed [19:0] vel_y;
    logic [20:0]        bvx;
    logic [20:0]        bvy;
    logic [11:0]        bj;

    function automatic logic [IW-1:0] wrap(input logic [IW-1:0] p);
        return (p == IW'(PARTICLES - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [8:0] slot9(input logic [IW-1:0] p);
        logic [XW-1:0] w;
        w = XW'(p);
        return w[8:0];
    endfunction

    function automatic logic [9:0] live10(input logic [CW-1:0] c);
        logic [LW-1:0] w;
        w = LW'(c);
        return w[9:0];
    endfunction

    // A result word that carries only a slot number and the live count.
    function automatic res_t count_only(input logic [8:0] s, input logic [9:0] n);
        res_t r;
        r      = '0;
        r.slot = s;
        r.live = n;
        return r;
    endfunction

    ppu_ram #(.WIDTH(RW), .DEPTH(PARTICLES)) u_pool (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );
    assign rdata = rec_t'(rdata_raw);

    assign rd_slot_x   = XW'(cmd_reg.slot_to_read);
    assign rd_in_range = {1'b0, rd_slot_x} < (XW + 1)'(PARTICLES);
    assign rd_idx      = rd_slot_x[IW-1:0];
    assign raddr       = (state_reg == ST_RD) ? rd_idx : ptr_reg;
    assign live_spawn  = live_reg + CW'(dead_reg);

    assign ready_for_words = (state_reg != ST_CLR);
    assign cmd_pop         = (state_reg == ST_IDLE) && cmd_valid;
    assign m_valid         = m_valid_reg;
    assign res             = out_reg;

    // Spawn arithmetic: biased values times a reciprocal of ten.
    assign bvx = 21'($signed({cmd_reg.source_vx[19], cmd_reg.source_vx})) + VEL_BIAS;
    assign bvy = 21'($signed({cmd_reg.source_vy[19], cmd_reg.source_vy})) + VEL_BIAS;
    assign bj  = {{1{cmd_reg.jitter[6]}}, cmd_reg.jitter, 4'b0000} + JIT_BIAS;

    always_ff @(posedge aclk) begin
        mvx_reg <= 41'(bvx) * 41'(RECIP10);
        mvy_reg <= 41'(bvy) * 41'(RECIP10);
        mj_reg  <= 24'(bj) * 24'(RECIP10_J);
    end

    assign vel_x = 20'($signed({1'b0, mvx_reg[40:23]}) - $signed({1'b0, VEL_UNBIAS}));
    assign vel_y = 20'($signed({1'b0, mvy_reg[40:23]}) - $signed({1'b0, VEL_UNBIAS}));
    assign jq    = $signed({1'b0, mj_reg[23:15]}) - $signed({1'b0, JIT_UNBIAS});

    always_comb begin
        spawn_rec       = '0;
        spawn_rec.life  = LIFE_FULL;
        spawn_rec.px    = sat20(22'(cmd_reg.source_x) + 22'(jq) + 22'(cmd_reg.shift_x));
        spawn_rec.py    = sat20(22'(cmd_reg.source_y) + 22'(jq) + 22'(cmd_reg.shift_y));
        spawn_rec.vx    = vel_x;
        spawn_rec.vy    = vel_y;
        spawn_rec.shade = cmd_reg.shade;
        spawn_rec.alpha = ALPHA_SPAWN;
    end

    // Tick stage one: life update and the two velocity products.
    assign life_new = (rdata.life > 17'(cmd_reg.step_time))
                    ? rdata.life - 17'(cmd_reg.step_time) : '0;

    // Tick stage two: rounded steps, saturation and the write back.
    assign step_x    = 21'((s2_mx_reg + 37'sd32768) >>> 16);
    assign step_y    = 21'((s2_my_reg + 37'sd32768) >>> 16);
    assign alpha_dec = 18'(s2_rec_reg.alpha) - $signed({1'b0, cmd_reg.alpha_step});

    always_comb begin
        tick_rec      = s2_rec_reg;
        tick_rec.life = s2_life_reg;
        if (s2_life_reg != '0) begin
            tick_rec.px    = sat20(22'(s2_rec_reg.px) - 22'(step_x));
            tick_rec.py    = sat20(22'(s2_rec_reg.py) - 22'(step_y));
            tick_rec.alpha = (alpha_dec < 18'(ALPHA_MIN)) ? ALPHA_MIN : alpha_dec[15:0];
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = '0;
        case (state_reg)
            ST_CLR: begin
                we = 1'b1;
            end
            ST_SPWR: begin
                we    = 1'b1;
                waddr = slot_reg;
                wdata = spawn_rec;
            end
            ST_TICK: begin
                we    = s2_valid_reg;
                waddr = s2_addr_reg;
                wdata = tick_rec;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            ptr_reg      <= '0;
            start_reg    <= '0;
            live_reg     <= '0;
            rd_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_RESP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR: begin
                    ptr_reg <= wrap(ptr_reg);
                    if (ptr_reg == IW'(PARTICLES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg      <= cmd;
                        issued_reg   <= '0;
                        chk_reg      <= '0;
                        acc_reg      <= '0;
                        rd_valid_reg <= 1'b0;
                        s2_valid_reg <= 1'b0;
                        case (cmd.op)
                            OP_SPAWN: begin
                                ptr_reg   <= start_reg;
                                state_reg <= ST_SCAN;
                            end
                            OP_TICK: begin
                                ptr_reg   <= '0;
                                state_reg <= ST_TICK;
                            end
                            OP_READ: begin
                                state_reg <= ST_RD;
                            end
                            default: begin
                                res_reg   <= count_only('0, live10(live_reg));
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (rd_valid_reg && rdata.life == '0) begin
                        slot_reg     <= rd_addr_reg;
                        dead_reg     <= 1'b1;
                        rd_valid_reg <= 1'b0;
                        state_reg    <= ST_SPWR;
                    end else if (rd_valid_reg && chk_reg == CW'(PARTICLES - 1)) begin
                        // Every slot is alive: slot 0 is taken over.
                        slot_reg     <= '0;
                        dead_reg     <= 1'b0;
                        rd_valid_reg <= 1'b0;
                        state_reg    <= ST_SPWR;
                    end else begin
                        chk_reg <= chk_reg + CW'(rd_valid_reg);
                        if (issued_reg != CW'(PARTICLES)) begin
                            rd_valid_reg <= 1'b1;
                            rd_addr_reg  <= ptr_reg;
                            ptr_reg      <= wrap(ptr_reg);
                            issued_reg   <= issued_reg + 1'b1;
                        end else begin
                            rd_valid_reg <= 1'b0;
                        end
                    end
                end
                ST_SPWR: begin
                    live_reg      <= live_spawn;
                    start_reg     <= slot_reg;
                    res_reg.slot  <= slot9(slot_reg);
                    res_reg.live  <= live10(live_spawn);
                    res_reg.alive <= 1'b1;
                    res_reg.x     <= spawn_rec.px;
                    res_reg.y     <= spawn_rec.py;
                    res_reg.shade <= spawn_rec.shade;
                    res_reg.alpha <= spawn_rec.alpha;
                    state_reg     <= ST_RESP;
                end
                ST_TICK: begin
                    if (issued_reg != CW'(PARTICLES)) begin
                        rd_valid_reg <= 1'b1;
                        rd_addr_reg  <= ptr_reg;
                        ptr_reg      <= wrap(ptr_reg);
                        issued_reg   <= issued_reg + 1'b1;
                    end else begin
                        rd_valid_reg <= 1'b0;
                    end
                    s2_valid_reg <= rd_valid_reg;
                    s2_addr_reg  <= rd_addr_reg;
                    s2_life_reg  <= life_new;
                    s2_rec_reg   <= rdata;
                    s2_mx_reg    <= rdata.vx * $signed({1'b0, cmd_reg.step_time});
                    s2_my_reg    <= rdata.vy * $signed({1'b0, cmd_reg.step_time});
                    if (s2_valid_reg && s2_life_reg != '0) begin
                        acc_reg <= acc_reg + 1'b1;
                    end
                    if (issued_reg == CW'(PARTICLES) && !rd_valid_reg && !s2_valid_reg) begin
                        live_reg  <= acc_reg;
                        res_reg   <= count_only('0, live10(acc_reg));
                        state_reg <= ST_RESP;
                    end
                end
                ST_RD: begin
                    if (rd_in_range) begin
                        state_reg <= ST_RDWAIT;
                    end else begin
                        res_reg   <= count_only(cmd_reg.slot_to_read, live10(live_reg));
                        state_reg <= ST_RESP;
                    end
                end
                ST_RDWAIT: begin
                    res_reg.slot  <= cmd_reg.slot_to_read;
                    res_reg.live  <= live10(live_reg);
                    res_reg.alive <= (rdata.life != '0);
                    res_reg.x     <= rdata.px;
                    res_reg.y     <= rdata.py;
                    res_reg.shade <= rdata.shade;
                    res_reg.alpha <= rdata.alpha;
                    state_reg     <= ST_RESP;
                end
                ST_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg     <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// File: sv/particle_pool_update.sv
// Top level of the particle pool: front queue and back-end engine.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | mode, step time, source, shift, jitter, shade, slot
//  m_      | out       | m_valid / m_ready  | slot, live count, alive, position, shade, alpha
//
// After reset the pool is cleared, and no word is taken meanwhile.
// A tick reads one pool entry per cycle from the pool RAM.
// A spawn runs a dead-slot scan, starting from the last slot spawned.
// A two-word queue lets the input side run ahead of the engine.
`timescale 1ns / 1ps
module particle_pool_update #(
    parameter int PARTICLES = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [15:0]        s_step_time,
    input  logic signed [19:0] s_source_x,
    input  logic signed [19:0] s_source_y,
    input  logic signed [19:0] s_source_vx,
    input  logic signed [19:0] s_source_vy,
    input  logic signed [19:0] s_shift_x,
    input  logic signed [19:0] s_shift_y,
    input  logic signed [6:0]  s_jitter_tenths,
    input  logic [6:0]         s_shade_hundredths,
    input  logic [8:0]         s_slot_to_read,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [8:0]         m_slot_chosen,
    output logic [9:0]         m_live_count,
    output logic               m_is_alive,
    output logic signed [19:0] m_particle_x,
    output logic signed [19:0] m_particle_y,
    output logic [6:0]         m_particle_shade,
    output logic signed [15:0] m_particle_alpha
);
    import ppu_pkg::*;

    logic enable;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    res_t res;

    ppu_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .enable             (enable),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_step_time        (s_step_time),
        .s_source_x         (s_source_x),
        .s_source_y         (s_source_y),
        .s_source_vx        (s_source_vx),
        .s_source_vy        (s_source_vy),
        .s_shift_x          (s_shift_x),
        .s_shift_y          (s_shift_y),
        .s_jitter_tenths    (s_jitter_tenths),
        .s_shade_hundredths (s_shade_hundredths),
        .s_slot_to_read     (s_slot_to_read),
        .cmd_valid          (cmd_valid),
        .cmd                (cmd),
        .cmd_pop            (cmd_pop)
    );

    ppu_engine #(.PARTICLES(PARTICLES)) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ready_for_words (enable),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .res             (res)
    );

    assign m_slot_chosen    = res.slot;
    assign m_live_count     = res.live;
    assign m_is_alive       = res.alive;
    assign m_particle_x     = res.x;
    assign m_particle_y     = res.y;
    assign m_particle_shade = res.shade;
    assign m_particle_alpha = res.alpha;
endmodule

// File: sv/ppu_checker.sv
// Port-level checker for the particle pool, bound to the top level.
`timescale 1ns / 1ps
`include "particle_pool_update_assert.svh"
module ppu_checker #(
    parameter int PARTICLES = 512
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_live_count,
    input logic       m_is_alive
);
    // The pool is being cleared right after reset, so no word is taken.
    `PPU_ASSERT_ALWAYS(a_no_accept_after_reset, !aresetn |=> !s_ready)
    `PPU_ASSERT(a_out_holds, m_valid && !m_ready |=> m_valid)
    `PPU_ASSERT(a_count_bound, m_valid |-> int'(m_live_count) <= PARTICLES)
    // The count is reported modulo 1024, so very large pools may wrap it to zero.
    `PPU_ASSERT(a_alive_counted, m_valid && m_is_alive |-> m_live_count != 10'd0 || PARTICLES > 1023)
endmodule

bind particle_pool_update ppu_checker #(.PARTICLES(PARTICLES)) u_ppu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_live_count (m_live_count),
    .m_is_alive   (m_is_alive)
);

// File: sim/particle_pool_update_tb.sv
// Self-checking testbench for the particle pool: directed table, then random words.
`timescale 1ns / 1ps
module particle_pool_update_tb;
    import ppu_pkg::*;

    localparam int POOL = 512;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        op_t             op;
        logic [15:0]     dt;
        logic signed [19:0] sx, sy, svx, svy, hx, hy;
        logic signed [6:0]  jit;
        logic [6:0]      shade;
        logic [8:0]      rslot;
    } word_t;

    typedef struct packed {
        logic [8:0]  slot;
        logic [9:0]  live;
        logic        alive;
        logic signed [19:0] x, y;
        logic [6:0]  shade;
        logic signed [15:0] alpha;
    } report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = '0;
    logic [15:0] s_step_time = '0;
    logic signed [19:0] s_source_x = '0, s_source_y = '0, s_source_vx = '0;
    logic signed [19:0] s_source_vy = '0, s_shift_x = '0, s_shift_y = '0;
    logic signed [6:0] s_jitter_tenths = '0;
    logic [6:0] s_shade_hundredths = '0;
    logic [8:0] s_slot_to_read = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [8:0] m_slot_chosen;
    logic [9:0] m_live_count;
    logic m_is_alive;
    logic signed [19:0] m_particle_x, m_particle_y;
    logic [6:0] m_particle_shade;
    logic signed [15:0] m_particle_alpha;

    particle_pool_update dut (.*);

    always #10 aclk = ~aclk;

    // Shadow copy of the pool.
    logic [16:0] life_sh [POOL];
    logic signed [19:0] px_sh [POOL], py_sh [POOL], vx_sh [POOL], vy_sh [POOL];
    logic [6:0] shade_sh [POOL];
    logic signed [15:0] alpha_sh [POOL];
    int unsigned scan_from;

    report_t pending_reports[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit recv_hold = 0;

    function automatic logic signed [19:0] clip20(longint v);
        if (v > 524287) return 20'sd524287;
        if (v < -524288) return -20'sd524288;
        return v[19:0];
    endfunction

    // Floor division; round_div rounds with ties toward plus infinity, by floor((2n+d)/(2d)).
    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && (n < 0)) q = q - 1;
        return q;
    endfunction

    function automatic longint round_div(longint n, longint d);
        return floor_div(2 * n + d, 2 * d);
    endfunction

    function automatic report_t apply_word(word_t w);
        report_t r;
        int unsigned slot;
        int unsigned n;
        longint jq, da, a;
        bit found;
        r = '{default: 0};
        case (w.op)
            OP_SPAWN: begin
                found = 0;
                slot = 0;
                for (int i = scan_from; i < POOL && !found; i++)
                    if (life_sh[i] == 0) begin slot = i; found = 1; end
                for (int i = 0; i < scan_from && !found; i++)
                    if (life_sh[i] == 0) begin slot = i; found = 1; end
                scan_from = slot;
                jq = round_div(longint'(w.jit) * 16, 10);
                px_sh[slot] = clip20(longint'(w.sx) + jq + longint'(w.hx));
                py_sh[slot] = clip20(longint'(w.sy) + jq + longint'(w.hy));
                vx_sh[slot] = 20'(round_div(longint'(w.svx), 10));
                vy_sh[slot] = 20'(round_div(longint'(w.svy), 10));
                shade_sh[slot] = w.shade;
                alpha_sh[slot] = ALPHA_SPAWN;
                life_sh[slot] = LIFE_FULL;
                r.slot = slot[8:0];
            end
            OP_TICK: begin
                da = (longint'(w.dt) * 5 + 4) >>> 3;
                for (int i = 0; i < POOL; i++) begin
                    life_sh[i] = (life_sh[i] > w.dt) ? life_sh[i] - w.dt : 17'd0;
                    if (life_sh[i] != 0) begin
                        px_sh[i] = clip20(longint'(px_sh[i])
                            - floor_div(longint'(vx_sh[i]) * w.dt + 32768, 65536));
                        py_sh[i] = clip20(longint'(py_sh[i])
                            - floor_div(longint'(vy_sh[i]) * w.dt + 32768, 65536));
                        a = longint'(alpha_sh[i]) - da;
                        alpha_sh[i] = (a < -32768) ? ALPHA_MIN : a[15:0];
                    end
                end
            end
            OP_READ: r.slot = w.rslot;
            default: ;
        endcase
        if (w.op == OP_SPAWN || w.op == OP_READ) begin
            slot = r.slot;
            r.alive = life_sh[slot] != 0;
            r.x = px_sh[slot];
            r.y = py_sh[slot];
            r.shade = shade_sh[slot];
            r.alpha = alpha_sh[slot];
        end
        n = 0;
        for (int i = 0; i < POOL; i++) if (life_sh[i] != 0) n++;
        r.live = n[9:0];
        return r;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int pick;
        pick = $urandom_range(99);
        w.op = (pick < 55) ? OP_SPAWN : (pick < 75) ? OP_TICK : (pick < 95) ? OP_READ : OP_NOP;
        // Short ticks keep particles alive long enough to move and fade.
        w.dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
        w.sx = 20'($urandom); w.sy = 20'($urandom);
        w.svx = 20'($urandom); w.svy = 20'($urandom);
        w.hx = ($urandom_range(3) == 0) ? 20'($urandom) : 20'(int'($urandom_range(200)) - 100);
        w.hy = ($urandom_range(3) == 0) ? 20'($urandom) : 20'(int'($urandom_range(200)) - 100);
        w.jit = 7'($urandom);
        w.shade = 7'($urandom);
        w.rslot = 9'($urandom);
        return w;
    endfunction

    // Valid stays high after an accepted word only when the next word follows at once.
    task automatic send_word(word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= w.op;
        s_step_time <= w.dt;
        s_source_x <= w.sx; s_source_y <= w.sy;
        s_source_vx <= w.svx; s_source_vy <= w.svy;
        s_shift_x <= w.hx; s_shift_y <= w.hy;
        s_jitter_tenths <= w.jit;
        s_shade_hundredths <= w.shade;
        s_slot_to_read <= w.rslot;
        do @(posedge aclk); while (!s_ready);
        pending_reports.push_back(apply_word(w));
        @(negedge aclk);
    endtask

    task automatic drain_pool_results();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (POOL + 10) @(negedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge aclk)
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            report_t e;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result word, slot %0d", m_slot_chosen);
            end else begin
                e = pending_reports.pop_front();
                if (m_slot_chosen !== e.slot || m_live_count !== e.live
                    || m_is_alive !== e.alive || m_particle_x !== e.x
                    || m_particle_y !== e.y || m_particle_shade !== e.shade
                    || m_particle_alpha !== e.alpha) begin
                    errors++;
                    if (errors <= 10) begin
                        $display({"Mismatch: exp slot %0d live %0d alive %0b x %0d y %0d",
                                  " sh %0d a %0d"},
                            e.slot, e.live, e.alive, e.x, e.y, e.shade, e.alpha);
                        $display({"          got slot %0d live %0d alive %0b x %0d y %0d",
                                  " sh %0d a %0d"},
                            m_slot_chosen, m_live_count, m_is_alive, m_particle_x,
                            m_particle_y, m_particle_shade, m_particle_alpha);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed rows: operation, step, source, velocity, shift, jitter, shade, slot.
    localparam int ROWS = 16;
    word_t plan [ROWS];
    // Expected values typed in where obvious; check_row marks rows checked directly.
    bit check_row [ROWS];
    report_t typed [ROWS];

    initial begin
        report_t got;
        for (int i = 0; i < POOL; i++) begin
            life_sh[i] = 0; px_sh[i] = 0; py_sh[i] = 0; vx_sh[i] = 0; vy_sh[i] = 0;
            shade_sh[i] = 0; alpha_sh[i] = 0;
        end
        scan_from = 0;
        plan[0]  = '{OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9'd0};
        plan[1]  = '{OP_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        plan[2]  = '{OP_SPAWN, 0, 20'sd524287, -20'sd524288, 20'sd524287, -20'sd524288,
                     20'sd524287, -20'sd524288, 7'sd49, 7'd99, 0};
        plan[3]  = '{OP_SPAWN, 0, -20'sd524288, 20'sd524287, -20'sd524288, 20'sd524287,
                     -20'sd524288, 20'sd524287, -7'sd50, 7'd0, 0};
        plan[4]  = '{OP_SPAWN, 0, 20'sd100, -20'sd100, 20'sd15, -20'sd15, 20'sd3, -20'sd3,
                     -7'sd64, 7'd127, 0};
        plan[5]  = '{OP_SPAWN, 0, 0, 0, 20'sd5, -20'sd5, 0, 0, 7'sd63, 7'd50, 0};
        plan[6]  = '{OP_NOP, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 0, 9'd7};
        plan[7]  = '{OP_TICK, 16'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        plan[8]  = '{OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9'd2};
        plan[9]  = '{OP_TICK, 16'd40000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        plan[10] = '{OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9'd0};
        plan[11] = '{OP_TICK, 16'd30000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        plan[12] = '{OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9'd511};
        plan[13] = '{OP_SPAWN, 0, 20'sd16, 20'sd16, 20'sd10, 20'sd10, 0, 0, 0, 7'd1, 0};
        plan[14] = '{OP_TICK, 16'd20000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        plan[15] = '{OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9'd0};
        for (int i = 0; i < ROWS; i++) check_row[i] = 0;
        check_row[0] = 1; typed[0] = '{default: 0};
        check_row[1] = 1; typed[1] = '{default: 0};
        check_row[2] = 1;
        typed[2] = '{9'd0, 10'd1, 1'b1, 20'sd524287, -20'sd524288, 7'd99, ALPHA_SPAWN};
        check_row[12] = 1; typed[12] = '{9'd511, 10'd0, 1'b0, 0, 0, 0, 0};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < ROWS; i++) begin
            send_word(plan[i]);
            got = pending_reports[$];
            if (check_row[i] && got != typed[i]) begin
                errors++;
                if (errors <= 10)
                    $display("Directed row %0d: expected %h, predicted %h",
                        i, typed[i], got);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 31 : 0;
            for (int k = 0; k < 150; k++) begin
                if (phase == 2 && k == 20) begin
                    // Hold the receiver off so the front queue fills and stalls input.
                    fork
                        begin
                            recv_hold = 1;
                            repeat (4000) @(negedge aclk);
                            recv_hold = 0;
                        end
                    join_none
                end
                if (phase == 2 && k == 100) drain_pool_results();
                send_word(random_word());
            end
        end

        drain_pool_results();
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/ppu_pkg.sv
sv/ppu_ram.sv
sv/ppu_front.sv
sv/ppu_engine.sv
sv/particle_pool_update.sv
sv/ppu_checker.sv
sim/particle_pool_update_tb.sv
